### rtl/core/lrp_pkg.sv
// Shared types and codes for the LR shift-reduce parser.
package lrp_pkg;

    typedef enum logic [2:0] {
        FUNC_TOKEN   = 3'd0,
        FUNC_ACTION  = 3'd1,
        FUNC_GOTO    = 3'd2,
        FUNC_PROD    = 3'd3,
        FUNC_RESTART = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_SHIFT  = 2'd1,
        KIND_REDUCE = 2'd2,
        KIND_ACCEPT = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        EV_SHIFT  = 2'd0,
        EV_REDUCE = 2'd1,
        EV_ACCEPT = 2'd2,
        EV_ERROR  = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        CAUSE_NONE      = 3'd0,
        CAUSE_NO_ACTION = 3'd1,
        CAUSE_UNDERFLOW = 3'd2,
        CAUSE_OVERFLOW  = 3'd3,
        CAUSE_LIMIT     = 3'd4
    } cause_t;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ACT_RD,
        ST_ACT_WAIT,
        ST_DECIDE,
        ST_PROD_WAIT,
        ST_BELOW_RD,
        ST_BELOW_WAIT,
        ST_GOTO_WAIT,
        ST_EMIT
    } bstate_t;

    // Classified command passed from front to back
    typedef struct packed {
        func_t       func;
        logic [4:0]  token;
        logic [5:0]  row_state;
        logic [4:0]  column;
        logic [1:0]  entry_kind;
        logic [5:0]  entry_value;
        logic [4:0]  prod_index;
        logic [3:0]  body_length;
        logic [3:0]  head_symbol;
    } cmd_t;

endpackage

### rtl/core/lr_shift_reduce_parser.sv
// LR shift-reduce parser top level.
//
// Input channel (in_valid/in_stall) carries one command per transaction:
// token, action/goto/production table write, or restart. Writes and restart
// give no result; each token gives one or more results on the output
// channel (out_valid/out_stall), the final one marked by last.
// A token walks dequeue, action read, wait and decide for a shift or accept,
// plus, per reduce, a production read, a stack read below the popped body,
// a goto read, then a fresh action read and decide, all set by the single
// sequencer in the back end walking its registered-read tables.
// Each result leaves through an output register in the cycle after its decision.
// Commands pass through a two-entry queue, so input can be taken while the
// back end works or waits on a stalled output register.
// After reset the action and goto tables are swept to zero, one entry per
// cycle until every entry of the larger table (2048 by default) is written;
// commands fill the queue meanwhile, then input stalls. The stack holds state
// zero, the block is not halted.
// A stalled output holds its result; the next result waits until it is taken.
// Accept or error halts the parser; each later token gets an error until a
// restart command.
module lr_shift_reduce_parser #(
    parameter int STATE_COUNT       = 64,
    parameter int TERMINAL_COUNT    = 32,
    parameter int NONTERMINAL_COUNT = 16,
    parameter int PRODUCTION_COUNT  = 32,
    parameter int STACK_DEPTH       = 64,
    parameter int REDUCE_LIMIT      = 63
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] func,
    input  logic [4:0] token,
    input  logic [5:0] row_state,
    input  logic [4:0] column,
    input  logic [1:0] entry_kind,
    input  logic [5:0] entry_value,
    input  logic [4:0] prod_index,
    input  logic [3:0] body_length,
    input  logic [3:0] head_symbol,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] event_res,
    output logic [5:0] state_after,
    output logic [4:0] production,
    output logic [2:0] error_cause,
    output logic       last
);
    lrp_pkg::cmd_t in_cmd, q_cmd;
    logic          q_valid, q_pop;

    // Pack the input fields into a command
    always_comb
    begin
        in_cmd.func        = lrp_pkg::func_t'(func);
        in_cmd.token       = token;
        in_cmd.row_state   = row_state;
        in_cmd.column      = column;
        in_cmd.entry_kind  = entry_kind;
        in_cmd.entry_value = entry_value;
        in_cmd.prod_index  = prod_index;
        in_cmd.body_length = body_length;
        in_cmd.head_symbol = head_symbol;
    end

    lrp_front #(
        .QDEPTH(2)
    ) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
        .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
    );

    lrp_back #(
        .STATE_COUNT(STATE_COUNT), .TERMINAL_COUNT(TERMINAL_COUNT),
        .NONTERMINAL_COUNT(NONTERMINAL_COUNT), .PRODUCTION_COUNT(PRODUCTION_COUNT),
        .STACK_DEPTH(STACK_DEPTH), .REDUCE_LIMIT(REDUCE_LIMIT)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
        .out_valid(out_valid), .out_stall(out_stall),
        .event_res(event_res), .state_after(state_after),
        .production(production), .error_cause(error_cause), .last(last)
    );
endmodule

### rtl/core/lrp_front.sv
// Front end: accepts input transactions, drops unused codes, queues commands.
module lrp_front #(
    parameter int QDEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  lrp_pkg::cmd_t     in_cmd,
    output logic              q_valid,
    output lrp_pkg::cmd_t     q_cmd,
    input  logic              q_pop
);
    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    lrp_pkg::cmd_t      mem_reg [QDEPTH];
    logic [AW-1:0]      wr_reg, wr_next, rd_reg, rd_next;
    logic [AW:0]        cnt_reg, cnt_next;
    logic               push, pop, known;

    // Only defined function codes enter the queue
    assign known = (in_cmd.func == lrp_pkg::FUNC_TOKEN) ||
                   (in_cmd.func == lrp_pkg::FUNC_ACTION) ||
                   (in_cmd.func == lrp_pkg::FUNC_GOTO) ||
                   (in_cmd.func == lrp_pkg::FUNC_PROD) ||
                   (in_cmd.func == lrp_pkg::FUNC_RESTART);
    assign in_stall = (cnt_reg == (AW+1)'(QDEPTH));
    assign push     = in_valid && !in_stall && known;
    assign pop      = q_pop && q_valid;
    assign q_valid  = (cnt_reg != '0);
    assign q_cmd    = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == AW'(QDEPTH-1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == AW'(QDEPTH-1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_cmd;
        end
    end
endmodule

### rtl/core/lrp_back.sv
// Back end: table memories, state stack and the parse sequencer.
module lrp_back #(
    parameter int STATE_COUNT       = 64,
    parameter int TERMINAL_COUNT    = 32,
    parameter int NONTERMINAL_COUNT = 16,
    parameter int PRODUCTION_COUNT  = 32,
    parameter int STACK_DEPTH       = 64,
    parameter int REDUCE_LIMIT      = 63
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  lrp_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [1:0]    event_res,
    output logic [5:0]    state_after,
    output logic [4:0]    production,
    output logic [2:0]    error_cause,
    output logic          last
);
    localparam int SW  = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
    localparam int TW  = (TERMINAL_COUNT > 1) ? $clog2(TERMINAL_COUNT) : 1;
    localparam int NW  = (NONTERMINAL_COUNT > 1) ? $clog2(NONTERMINAL_COUNT) : 1;
    localparam int PW  = (PRODUCTION_COUNT > 1) ? $clog2(PRODUCTION_COUNT) : 1;
    localparam int KW  = $clog2(STACK_DEPTH);
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int AD  = STATE_COUNT * TERMINAL_COUNT;
    localparam int GD  = STATE_COUNT * NONTERMINAL_COUNT;
    localparam int AAW = SW + TW;
    localparam int GAW = SW + NW;
    localparam int CLW = (AD > GD) ? AAW : GAW;
    localparam int RW  = 6;

    // Memories
    logic [7:0]      act_mem  [AD];
    logic [5:0]      goto_mem [GD];
    logic [7:0]      prod_mem [PRODUCTION_COUNT];
    logic [5:0]      stk_mem  [STACK_DEPTH];

    lrp_pkg::bstate_t state_reg, state_next;
    logic [CLW:0]     clr_reg, clr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [5:0]       top_reg, top_next;
    logic [RW-1:0]    red_reg, red_next;
    logic             halt_reg, halt_next;
    logic [4:0]       tok_reg, tok_next;
    logic [5:0]       pv_reg, pv_next;
    logic [CW-1:0]    nc_reg, nc_next;
    logic [3:0]       hd_reg, hd_next;
    logic             ov_reg;

    // Output register
    logic             ov_next;
    logic [1:0]       oev_reg, oev_next;
    logic [5:0]       ost_reg, ost_next;
    logic [4:0]       opr_reg, opr_next;
    logic [2:0]       oca_reg, oca_next;
    logic             ola_reg, ola_next;

    // Memory read data
    logic [7:0]       act_q, prod_q;
    logic [5:0]       goto_q, stk_q;
    logic [5:0]       below;
    logic [AAW-1:0]   act_ra;
    logic [GAW-1:0]   goto_ra;
    logic [KW-1:0]    stk_ra;
    logic             act_in, goto_in;

    // Write controls
    logic             act_we, goto_we, prod_we, stk_we;
    logic [AAW-1:0]   act_wa;
    logic [GAW-1:0]   goto_wa;
    logic [KW-1:0]    stk_wa;
    logic [7:0]       act_wd;
    logic [5:0]       goto_wd, stk_wd;

    logic             out_free;
    logic             emit;
    logic [1:0]       e_ev;
    logic [5:0]       e_st;
    logic [4:0]       e_pr;
    logic [2:0]       e_ca;
    logic             e_la;
    logic [1:0]       ek;
    logic [5:0]       evl;
    logic [3:0]       plen;
    logic [CW-1:0]    newc;
    logic             halt_set;

    assign out_free = !ov_reg || !out_stall;
    assign ek  = act_in ? act_q[7:6] : lrp_pkg::KIND_NONE;
    assign evl = act_q[5:0];
    assign plen = prod_q[7:4];
    assign newc = cnt_reg - CW'(plen);

    // Stack entry zero is never written; a read of it is replaced by state zero
    assign below   = (nc_reg == CW'(1)) ? 6'd0 : stk_q;

    assign act_in  = (32'(top_reg) < STATE_COUNT) && (32'(tok_reg) < TERMINAL_COUNT);
    assign act_ra  = {SW'(top_reg), TW'(tok_reg)};
    assign goto_in = (32'(below) < STATE_COUNT) && (32'(hd_reg) < NONTERMINAL_COUNT);
    assign goto_ra = {SW'(below), NW'(hd_reg)};
    assign stk_ra  = KW'(nc_reg - 1'b1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lrp_pkg::ST_CLEAR:
            begin
                if (clr_reg == (CLW+1)'((AD > GD) ? AD - 1 : GD - 1))
                begin
                    state_next = lrp_pkg::ST_IDLE;
                end
            end
            lrp_pkg::ST_IDLE:
            begin
                if (q_valid && q_cmd.func == lrp_pkg::FUNC_TOKEN)
                begin
                    if (halt_reg)
                    begin
                        state_next = out_free ? lrp_pkg::ST_IDLE : lrp_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = lrp_pkg::ST_ACT_RD;
                    end
                end
            end
            lrp_pkg::ST_ACT_RD:   state_next = lrp_pkg::ST_ACT_WAIT;
            lrp_pkg::ST_ACT_WAIT: state_next = lrp_pkg::ST_DECIDE;
            lrp_pkg::ST_DECIDE:
            begin
                if (out_free)
                begin
                    if (ek == lrp_pkg::KIND_REDUCE && red_reg != RW'(REDUCE_LIMIT)
                        && 32'(evl) < PRODUCTION_COUNT)
                    begin
                        state_next = lrp_pkg::ST_PROD_WAIT;
                    end
                    else
                    begin
                        state_next = lrp_pkg::ST_IDLE;
                    end
                end
            end
            lrp_pkg::ST_PROD_WAIT:
            begin
                if (CW'(plen) >= cnt_reg || newc >= CW'(STACK_DEPTH))
                begin
                    if (out_free)
                    begin
                        state_next = lrp_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    state_next = lrp_pkg::ST_BELOW_RD;
                end
            end
            lrp_pkg::ST_BELOW_RD:   state_next = lrp_pkg::ST_BELOW_WAIT;
            lrp_pkg::ST_BELOW_WAIT: state_next = lrp_pkg::ST_GOTO_WAIT;
            lrp_pkg::ST_GOTO_WAIT:
            begin
                if (out_free)
                begin
                    state_next = lrp_pkg::ST_ACT_RD;
                end
            end
            default: state_next = lrp_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath updates
    always_comb
    begin
        clr_next = clr_reg;
        cnt_next = cnt_reg;
        top_next = top_reg;
        red_next = red_reg;
        halt_next = halt_reg;
        tok_next = tok_reg;
        pv_next  = pv_reg;
        nc_next  = nc_reg;
        hd_next  = hd_reg;
        q_pop    = 1'b0;
        emit     = 1'b0;
        e_ev = lrp_pkg::EV_ERROR;
        e_st = top_reg;
        e_pr = '0;
        e_ca = lrp_pkg::CAUSE_NONE;
        e_la = 1'b1;
        halt_set = 1'b0;
        act_we  = 1'b0;
        goto_we = 1'b0;
        prod_we = 1'b0;
        stk_we  = 1'b0;
        act_wa  = {SW'(q_cmd.row_state), TW'(q_cmd.column)};
        goto_wa = {SW'(q_cmd.row_state), NW'(q_cmd.column)};
        act_wd  = {q_cmd.entry_kind, q_cmd.entry_value};
        goto_wd = q_cmd.entry_value;
        stk_wa  = KW'(cnt_reg);
        stk_wd  = evl;
        case (state_reg)
            lrp_pkg::ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                act_we  = (32'(clr_reg) < AD);
                goto_we = (32'(clr_reg) < GD);
                act_wa  = AAW'(clr_reg);
                goto_wa = GAW'(clr_reg);
                act_wd  = '0;
                goto_wd = '0;
            end
            lrp_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_cmd.func)
                        lrp_pkg::FUNC_ACTION:
                        begin
                            q_pop  = 1'b1;
                            act_we = (32'(q_cmd.row_state) < STATE_COUNT) &&
                                     (32'(q_cmd.column) < TERMINAL_COUNT);
                        end
                        lrp_pkg::FUNC_GOTO:
                        begin
                            q_pop   = 1'b1;
                            goto_we = (32'(q_cmd.row_state) < STATE_COUNT) &&
                                      (32'(q_cmd.column) < NONTERMINAL_COUNT);
                        end
                        lrp_pkg::FUNC_PROD:
                        begin
                            q_pop   = 1'b1;
                            prod_we = (32'(q_cmd.prod_index) < PRODUCTION_COUNT);
                        end
                        lrp_pkg::FUNC_RESTART:
                        begin
                            q_pop     = 1'b1;
                            cnt_next  = CW'(1);
                            top_next  = '0;
                            halt_next = 1'b0;
                        end
                        lrp_pkg::FUNC_TOKEN:
                        begin
                            if (halt_reg)
                            begin
                                if (out_free)
                                begin
                                    q_pop = 1'b1;
                                    emit  = 1'b1;
                                    e_ca  = lrp_pkg::CAUSE_LIMIT;
                                end
                            end
                            else
                            begin
                                q_pop    = 1'b1;
                                tok_next = q_cmd.token;
                                red_next = '0;
                            end
                        end
                        default: q_pop = 1'b1;
                    endcase
                end
            end
            lrp_pkg::ST_DECIDE:
            begin
                if (out_free)
                begin
                    case (ek)
                        lrp_pkg::KIND_NONE:
                        begin
                            emit = 1'b1;
                            e_ca = lrp_pkg::CAUSE_NO_ACTION;
                            halt_set = 1'b1;
                        end
                        lrp_pkg::KIND_ACCEPT:
                        begin
                            emit = 1'b1;
                            e_ev = lrp_pkg::EV_ACCEPT;
                            halt_set = 1'b1;
                        end
                        lrp_pkg::KIND_SHIFT:
                        begin
                            emit = 1'b1;
                            if (cnt_reg >= CW'(STACK_DEPTH))
                            begin
                                e_ca = lrp_pkg::CAUSE_OVERFLOW;
                                halt_set = 1'b1;
                            end
                            else
                            begin
                                e_ev = lrp_pkg::EV_SHIFT;
                                e_st = evl;
                                stk_we = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                                top_next = evl;
                            end
                        end
                        default:
                        begin
                            pv_next = evl;
                            if (red_reg == RW'(REDUCE_LIMIT))
                            begin
                                emit = 1'b1;
                                e_ca = lrp_pkg::CAUSE_LIMIT;
                                halt_set = 1'b1;
                            end
                            else if (32'(evl) >= PRODUCTION_COUNT)
                            begin
                                emit = 1'b1;
                                e_ca = lrp_pkg::CAUSE_NO_ACTION;
                                halt_set = 1'b1;
                            end
                        end
                    endcase
                end
            end
            lrp_pkg::ST_PROD_WAIT:
            begin
                nc_next = newc;
                hd_next = prod_q[3:0];
                if (CW'(plen) >= cnt_reg)
                begin
                    emit = out_free;
                    e_ca = lrp_pkg::CAUSE_UNDERFLOW;
                    halt_set = out_free;
                end
                else if (newc >= CW'(STACK_DEPTH))
                begin
                    emit = out_free;
                    e_ca = lrp_pkg::CAUSE_OVERFLOW;
                    halt_set = out_free;
                end
            end
            lrp_pkg::ST_GOTO_WAIT:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    e_ev = lrp_pkg::EV_REDUCE;
                    e_st = goto_in ? goto_q : '0;
                    e_pr = 5'(pv_reg);
                    e_la = 1'b0;
                    stk_we = 1'b1;
                    stk_wa = KW'(nc_reg);
                    stk_wd = e_st;
                    cnt_next = nc_reg + 1'b1;
                    top_next = e_st;
                    red_next = red_reg + 1'b1;
                end
            end
            default: ;
        endcase
        if (halt_set)
        begin
            halt_next = 1'b1;
        end
    end

    // Output register load
    always_comb
    begin
        ov_next  = ov_reg && out_stall;
        oev_next = oev_reg;
        ost_next = ost_reg;
        opr_next = opr_reg;
        oca_next = oca_reg;
        ola_next = ola_reg;
        if (emit)
        begin
            ov_next  = 1'b1;
            oev_next = e_ev;
            ost_next = e_st;
            opr_next = e_pr;
            oca_next = e_ca;
            ola_next = e_la;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lrp_pkg::ST_CLEAR;
            clr_reg   <= '0;
            cnt_reg   <= CW'(1);
            top_reg   <= '0;
            red_reg   <= '0;
            halt_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cnt_reg   <= cnt_next;
            top_reg   <= top_next;
            red_reg   <= red_next;
            halt_reg  <= halt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        pv_reg  <= pv_next;
        nc_reg  <= nc_next;
        hd_reg  <= hd_next;
        oev_reg <= oev_next;
        ost_reg <= ost_next;
        opr_reg <= opr_next;
        oca_reg <= oca_next;
        ola_reg <= ola_next;
    end

    // Action table
    always_ff @(posedge clk)
    begin
        if (act_we)
        begin
            act_mem[act_wa] <= act_wd;
        end
        act_q <= act_mem[act_ra];
    end

    // Goto table
    always_ff @(posedge clk)
    begin
        if (goto_we)
        begin
            goto_mem[goto_wa] <= goto_wd;
        end
        goto_q <= goto_mem[goto_ra];
    end

    // Production table
    always_ff @(posedge clk)
    begin
        if (prod_we)
        begin
            prod_mem[PW'(q_cmd.prod_index)] <= {q_cmd.body_length, q_cmd.head_symbol};
        end
        prod_q <= prod_mem[PW'(pv_next)];
    end

    // State stack
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_wa] <= stk_wd;
        end
        stk_q <= stk_mem[stk_ra];
    end

    assign out_valid   = ov_reg;
    assign event_res   = oev_reg;
    assign state_after = ost_reg;
    assign production  = opr_reg;
    assign error_cause = oca_reg;
    assign last        = ola_reg;
endmodule

### tb/lr_shift_reduce_parser_tb.sv
// Self-checking testbench for the LR shift-reduce parser: table loads, parse walks and errors.
module lr_shift_reduce_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_STATE = 64;
    localparam int N_TERM  = 32;
    localparam int N_NT    = 16;
    localparam int N_PROD  = 32;
    localparam int DEPTH   = 64;
    localparam int RLIMIT  = 63;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int ITEM_TARGET = 280;
    localparam logic [2:0] FUNC_UNUSED = 3'd7;

    typedef struct {
        logic [2:0] func;
        logic [4:0] token;
        logic [5:0] row_state;
        logic [4:0] column;
        logic [1:0] entry_kind;
        logic [5:0] entry_value;
        logic [4:0] prod_index;
        logic [3:0] body_length;
        logic [3:0] head_symbol;
    } cmd_item_t;

    typedef struct {
        lrp_pkg::event_t ev;
        logic [5:0]      st;
        logic [4:0]      prod;
        lrp_pkg::cause_t cause;
        logic            fin;
    } parse_event_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] func;
    logic [4:0] token;
    logic [5:0] row_state;
    logic [4:0] column;
    logic [1:0] entry_kind;
    logic [5:0] entry_value;
    logic [4:0] prod_index;
    logic [3:0] body_length;
    logic [3:0] head_symbol;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] event_res;
    logic [5:0] state_after;
    logic [4:0] production;
    logic [2:0] error_cause;
    logic       last;

    lr_shift_reduce_parser u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .token(token), .row_state(row_state), .column(column),
        .entry_kind(entry_kind), .entry_value(entry_value), .prod_index(prod_index),
        .body_length(body_length), .head_symbol(head_symbol),
        .out_valid(out_valid), .out_stall(out_stall),
        .event_res(event_res), .state_after(state_after), .production(production),
        .error_cause(error_cause), .last(last)
    );

    // Shadow copy of the parser tables and stack
    logic [1:0] sh_kind [N_STATE*N_TERM];
    logic [5:0] sh_val  [N_STATE*N_TERM];
    logic [5:0] sh_goto [N_STATE*N_NT];
    logic [3:0] sh_len  [N_PROD];
    logic [3:0] sh_head [N_PROD];
    logic [5:0] sh_stack [DEPTH];
    int         sh_depth;
    bit         sh_halted;

    parse_event_t pending_events[$];
    int  errors;
    int  sent_items;
    int  checked_events;
    int  cycles;
    bit  no_idle;
    bit  hold_req;
    bit  hold_active;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: random stall, plus a long counted hold-off on request
    initial
    begin
        int n;
        out_stall = 1'b1;
        hold_active = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_active)
            begin
                hold_active = 1'b1;
                out_stall <= 1'b1;
                for (n = 0; n < 400; n++) @(posedge clk);
                hold_active = 1'b0;
            end
            out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 23);
        end
    end

    // Output checker
    always @(posedge clk)
    begin
        parse_event_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_events.size() == 0)
            begin
                $error("unexpected result ev=%0d st=%0d", event_res, state_after);
                errors++;
            end
            else
            begin
                e = pending_events.pop_front();
                checked_events++;
                if (event_res !== e.ev)
                begin
                    $error("event_res exp %0d got %0d", e.ev, event_res); errors++;
                end
                if (state_after !== e.st)
                begin
                    $error("state_after exp %0d got %0d", e.st, state_after); errors++;
                end
                if (production !== e.prod)
                begin
                    $error("production exp %0d got %0d", e.prod, production); errors++;
                end
                if (error_cause !== e.cause)
                begin
                    $error("error_cause exp %0d got %0d", e.cause, error_cause); errors++;
                end
                if (last !== e.fin)
                begin
                    $error("last exp %0d got %0d", e.fin, last); errors++;
                end
            end
        end
    end

    function automatic logic [5:0] top_of_stack();
        if (sh_depth == 0 || sh_depth > DEPTH) return 6'd0;
        return sh_stack[sh_depth-1];
    endfunction

    function automatic void push_event(lrp_pkg::event_t ev, logic [5:0] st,
                                       logic [4:0] prod, lrp_pkg::cause_t cause,
                                       logic fin);
        parse_event_t e;
        e.ev = ev; e.st = st; e.prod = prod; e.cause = cause; e.fin = fin;
        pending_events.push_back(e);
    endfunction

    function automatic void parse_fail(lrp_pkg::cause_t cause);
        push_event(lrp_pkg::EV_ERROR, top_of_stack(), 5'd0, cause, 1'b1);
        sh_halted = 1'b1;
    endfunction

    // Walk the shadow tables for one token
    function automatic void walk_token(logic [4:0] tok);
        int reduces;
        int idx;
        int newd;
        logic [5:0] st;
        logic [5:0] gs;
        logic [5:0] below;
        logic [1:0] k;
        logic [5:0] v;
        reduces = 0;
        if (sh_halted)
        begin
            parse_fail(lrp_pkg::CAUSE_LIMIT);
            return;
        end
        forever
        begin
            st = top_of_stack();
            idx = st * N_TERM + tok;
            k = sh_kind[idx];
            v = sh_val[idx];
            if (k == lrp_pkg::KIND_NONE)
            begin
                parse_fail(lrp_pkg::CAUSE_NO_ACTION);
                return;
            end
            if (k == lrp_pkg::KIND_ACCEPT)
            begin
                push_event(lrp_pkg::EV_ACCEPT, st, 5'd0, lrp_pkg::CAUSE_NONE, 1'b1);
                sh_halted = 1'b1;
                return;
            end
            if (k == lrp_pkg::KIND_SHIFT)
            begin
                if (sh_depth >= DEPTH)
                begin
                    parse_fail(lrp_pkg::CAUSE_OVERFLOW);
                    return;
                end
                sh_stack[sh_depth] = v;
                sh_depth++;
                push_event(lrp_pkg::EV_SHIFT, v, 5'd0, lrp_pkg::CAUSE_NONE, 1'b1);
                return;
            end
            if (reduces >= RLIMIT)
            begin
                parse_fail(lrp_pkg::CAUSE_LIMIT);
                return;
            end
            if (v >= N_PROD)
            begin
                parse_fail(lrp_pkg::CAUSE_NO_ACTION);
                return;
            end
            if (sh_len[v] >= sh_depth)
            begin
                parse_fail(lrp_pkg::CAUSE_UNDERFLOW);
                return;
            end
            newd = sh_depth - sh_len[v];
            if (newd >= DEPTH)
            begin
                parse_fail(lrp_pkg::CAUSE_OVERFLOW);
                return;
            end
            below = sh_stack[newd-1];
            gs = sh_goto[below * N_NT + sh_head[v]];
            sh_stack[newd] = gs;
            sh_depth = newd + 1;
            push_event(lrp_pkg::EV_REDUCE, gs, v[4:0], lrp_pkg::CAUSE_NONE, 1'b0);
            reduces++;
        end
    endfunction

    function automatic void predict_item(cmd_item_t c);
        case (c.func)
            lrp_pkg::FUNC_ACTION:
            begin
                sh_kind[c.row_state * N_TERM + c.column] = c.entry_kind;
                sh_val[c.row_state * N_TERM + c.column]  = c.entry_value;
            end
            lrp_pkg::FUNC_GOTO:
            begin
                if (c.column < N_NT) sh_goto[c.row_state * N_NT + c.column] = c.entry_value;
            end
            lrp_pkg::FUNC_PROD:
            begin
                sh_len[c.prod_index]  = c.body_length;
                sh_head[c.prod_index] = c.head_symbol;
            end
            lrp_pkg::FUNC_RESTART:
            begin
                sh_stack[0] = 6'd0;
                sh_depth = 1;
                sh_halted = 1'b0;
            end
            lrp_pkg::FUNC_TOKEN: walk_token(c.token);
            default: ;
        endcase
    endfunction

    // Drive one transaction and wait until it is taken
    task automatic send_cmd(cmd_item_t c);
        while (!no_idle && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= c.func;
        token       <= c.token;
        row_state   <= c.row_state;
        column      <= c.column;
        entry_kind  <= c.entry_kind;
        entry_value <= c.entry_value;
        prod_index  <= c.prod_index;
        body_length <= c.body_length;
        head_symbol <= c.head_symbol;
        predict_item(c);
        sent_items++;
        do @(posedge clk); while (in_stall);
    endtask

    function automatic cmd_item_t rand_fields();
        cmd_item_t c;
        c.func = 3'($urandom_range(7));
        c.token = 5'($urandom); c.row_state = 6'($urandom); c.column = 5'($urandom);
        c.entry_kind = 2'($urandom); c.entry_value = 6'($urandom);
        c.prod_index = 5'($urandom); c.body_length = 4'($urandom);
        c.head_symbol = 4'($urandom);
        return c;
    endfunction

    task automatic wr_action(int r, int col, lrp_pkg::kind_t k, int v);
        cmd_item_t c;
        c = rand_fields();
        c.func = lrp_pkg::FUNC_ACTION; c.row_state = 6'(r); c.column = 5'(col);
        c.entry_kind = k; c.entry_value = 6'(v);
        send_cmd(c);
    endtask

    task automatic wr_goto(int r, int col, int v);
        cmd_item_t c;
        c = rand_fields();
        c.func = lrp_pkg::FUNC_GOTO; c.row_state = 6'(r); c.column = 5'(col);
        c.entry_value = 6'(v);
        send_cmd(c);
    endtask

    task automatic wr_prod(int p, int len, int hd);
        cmd_item_t c;
        c = rand_fields();
        c.func = lrp_pkg::FUNC_PROD; c.prod_index = 5'(p); c.body_length = 4'(len);
        c.head_symbol = 4'(hd);
        send_cmd(c);
    endtask

    task automatic send_token(int t);
        cmd_item_t c;
        c = rand_fields();
        c.func = lrp_pkg::FUNC_TOKEN; c.token = 5'(t);
        send_cmd(c);
    endtask

    task automatic send_restart();
        cmd_item_t c;
        c = rand_fields();
        c.func = lrp_pkg::FUNC_RESTART;
        send_cmd(c);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge clk);
    endtask

    // Every production gets a definition before any token can reduce by it
    task automatic test_production_load();
        int p;
        for (p = 0; p < N_PROD; p++) wr_prod(p, $urandom_range(3), $urandom_range(15));
        wr_prod(31, 15, 15);
        wr_prod(0, 0, 0);
    endtask

    // Small grammar: shift, reduce chain, accept, halted token, restart, then error cases
    task automatic test_directed_parse();
        cmd_item_t c;
        wr_action(0, 1, lrp_pkg::KIND_SHIFT, 63);
        wr_action(63, 2, lrp_pkg::KIND_REDUCE, 1);
        wr_prod(1, 1, 2);
        wr_goto(0, 2, 5);
        wr_goto(0, 20, 9);                 // column beyond goto table: ignored
        wr_action(5, 2, lrp_pkg::KIND_REDUCE, 2);
        wr_prod(2, 1, 3);
        wr_goto(0, 3, 6);
        wr_action(6, 2, lrp_pkg::KIND_ACCEPT, 0);
        c = rand_fields(); c.func = FUNC_UNUSED; send_cmd(c);
        send_token(1);
        send_token(2);
        send_token(2);                     // block now halted
        send_restart();
        send_token(31);                    // no action entry
        send_restart();
        wr_action(0, 31, lrp_pkg::KIND_REDUCE, 40); // production out of range
        send_token(31);
        send_restart();
        wr_action(0, 30, lrp_pkg::KIND_REDUCE, 31); // body 15 on a one-deep stack
        send_token(30);
        drain();
    endtask

    // Zero-length reduce looping on itself runs into the reduce limit
    task automatic test_reduce_limit();
        send_restart();
        wr_prod(4, 0, 7);
        wr_goto(0, 7, 0);
        wr_action(0, 4, lrp_pkg::KIND_REDUCE, 4);
        send_token(4);
        drain();
    endtask

    // Self-loop shifts fill the stack; receiver holds off meanwhile
    task automatic test_overflow_backpressure();
        int i;
        send_restart();
        wr_action(0, 9, lrp_pkg::KIND_SHIFT, 12);
        wr_action(12, 9, lrp_pkg::KIND_SHIFT, 12);
        hold_req = 1'b1;
        no_idle = 1'b1;
        for (i = 0; i < DEPTH + 1; i++) send_token(9);
        hold_req = 1'b0;
        no_idle = 1'b0;
        drain();
    endtask

    // Random small grammars followed by token streams
    task automatic test_random_grammars();
        int i;
        int n;
        int kd;
        cmd_item_t c;
        while (sent_items < ITEM_TARGET)
        begin
            no_idle = ($urandom_range(9) == 0);
            for (i = 0; i < 6; i++)
            begin
                n = $urandom_range(99);
                if (n < 60)
                begin
                    kd = ($urandom_range(9) == 0) ? 3 : $urandom_range(2);
                    wr_action($urandom_range(7), $urandom_range(3),
                              lrp_pkg::kind_t'(2'(kd)),
                              $urandom_range(99) < 70 ? $urandom_range(7) : $urandom_range(63));
                end
                else if (n < 85)
                    wr_goto($urandom_range(7), $urandom_range(3), $urandom_range(7));
                else
                    wr_prod($urandom_range(7), $urandom_range(9) == 0 ? 15 : $urandom_range(2),
                            $urandom_range(3));
            end
            send_restart();
            for (i = 0; i < 12; i++)
            begin
                if ($urandom_range(9) == 0)
                begin
                    c = rand_fields();
                    // keep productions defined
                    if (c.func == lrp_pkg::FUNC_PROD) c.func = lrp_pkg::FUNC_TOKEN;
                    if (c.func == lrp_pkg::FUNC_ACTION && c.entry_kind == lrp_pkg::KIND_REDUCE)
                        c.entry_kind = lrp_pkg::KIND_SHIFT;
                    send_cmd(c);
                end
                else
                    send_token($urandom_range(3));
            end
        end
        no_idle = 1'b0;
        drain();
    endtask

    initial
    begin
        errors = 0; sent_items = 0; checked_events = 0; cycles = 0;
        no_idle = 1'b0; hold_req = 1'b0;
        foreach (sh_kind[i])
        begin
            sh_kind[i] = lrp_pkg::KIND_NONE; sh_val[i] = '0;
        end
        foreach (sh_goto[i]) sh_goto[i] = '0;
        foreach (sh_len[i])
        begin
            sh_len[i] = '0; sh_head[i] = '0;
        end
        foreach (sh_stack[i]) sh_stack[i] = '0;
        sh_depth = 1; sh_halted = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = '0; token = '0; row_state = '0; column = '0; entry_kind = '0;
        entry_value = '0; prod_index = '0; body_length = '0; head_symbol = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_production_load();
        test_directed_parse();
        test_reduce_limit();
        test_overflow_backpressure();
        test_random_grammars();

        repeat (50) @(posedge clk);
        $display("Covered %0d transactions in, %0d parse events checked:", sent_items,
                 checked_events);
        $display("shift/reduce/accept walks, halt, restart, underflow, overflow, reduce limit.");
        if (errors == 0 && pending_events.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
